/* hdl/tcsw_pkg.sv */
// Package for the text console screen writer: beat types, character codes
// and default geometry. Used by every module of the block.
package tcsw_pkg;

  localparam int SCREEN_WIDTH_DEF  = 80;
  localparam int SCREEN_HEIGHT_DEF = 25;

  localparam logic [7:0]  CH_NEWLINE   = 8'd10;
  localparam logic [7:0]  CH_BACKSPACE = 8'd8;
  localparam logic [7:0]  CH_SPACE     = 8'd32;
  localparam logic [7:0]  RESET_ATTR   = 8'h07;
  localparam logic [15:0] RESET_CELL   = {RESET_ATTR, CH_SPACE};

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef logic [15:0] cell_t;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    cell_t      cell_value;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
  } out_item_t;

endpackage

/* hdl/text_console_screen_writer_unit.sv */
// Top level of the text console screen writer: cursor control, scroll
// sequencer and result register around the screen cell memory.
// Depends on tcsw_pkg and tcsw_cell_ram.

// Text console with a grid of SCREEN_HEIGHT x SCREEN_WIDTH 16-bit cells held
// in one memory with a single write port. After reset the block runs a
// clearing pass that fills every cell with a grey space; in_stall stays
// high until it ends. A put, newline or backspace is accepted and touches
// the memory in ST_IDLE, then loads the result register in ST_FINISH once
// that register is free. A read also passes through ST_READ, waiting on the
// registered read data. A put or newline that runs past the last row
// scrolls the grid through the memory one cell per cycle, copy then blank
// of the bottom row, before its result is loaded. The result register lets
// the next beat be accepted while an earlier result still waits on out_stall.
module text_console_screen_writer_unit #(
  parameter int SCREEN_WIDTH  = tcsw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tcsw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcsw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tcsw_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);
  import tcsw_pkg::*;

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(SCREEN_WIDTH);
  localparam int RW    = $clog2(SCREEN_HEIGHT);

  localparam logic [AW-1:0] LAST_ADDR   = AW'(DEPTH - 1);
  localparam logic [AW-1:0] BOTTOM_ADDR = AW'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
  localparam logic [AW-1:0] COPY_LAST   = AW'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH - 1);
  localparam logic [AW-1:0] ROW_STRIDE  = AW'(SCREEN_WIDTH);
  localparam logic [CW-1:0] LAST_COL    = CW'(SCREEN_WIDTH - 1);
  localparam logic [RW-1:0] LAST_ROW    = RW'(SCREEN_HEIGHT - 1);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_SCROLL = 6'b001000,
    ST_BLANK  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [7:0]    attr;
  logic [RW-1:0] row;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col;
  logic [CW-1:0] col_next;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] cur_addr_next;
  logic [AW-1:0] ptr;
  logic          copy_pend;
  logic [AW-1:0] copy_addr;
  logic          read_ok;
  cell_t         pend_value;

  logic          accept;
  logic          go_scroll;
  logic          put_we;
  logic [AW-1:0] put_addr;
  cell_t         put_data;
  logic          in_range;
  logic [AW-1:0] read_addr;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  cell_t         ram_wdata;
  logic [AW-1:0] ram_raddr;
  cell_t         ram_rdata;
  cell_t         blank_cell;
  logic          out_free;

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && (state == ST_IDLE);
  assign blank_cell = {attr, CH_SPACE};
  assign out_free   = !out_valid || !out_stall;

  assign in_range  = (32'(in_data.read_row) < 32'(SCREEN_HEIGHT)) &&
                     (32'(in_data.read_col) < 32'(SCREEN_WIDTH));
  assign read_addr = in_range ?
                     AW'(in_data.read_row) * ROW_STRIDE + AW'(in_data.read_col) :
                     '0;

  // Cursor update and the memory write that a put beat causes.
  always_comb begin
    row_next      = row;
    col_next      = col;
    cur_addr_next = cur_addr;
    go_scroll     = 1'b0;
    put_we        = 1'b0;
    put_addr      = cur_addr;
    put_data      = {attr, in_data.char_code};
    if (in_data.command == CMD_PUT) begin
      if (in_data.char_code == CH_NEWLINE) begin
        col_next = '0;
        if (row == LAST_ROW) begin
          go_scroll     = 1'b1;
          row_next      = LAST_ROW;
          cur_addr_next = BOTTOM_ADDR;
        end else begin
          row_next      = row + RW'(1);
          cur_addr_next = cur_addr + ROW_STRIDE - AW'(col);
        end
      end else if (in_data.char_code == CH_BACKSPACE) begin
        if (col != '0) begin
          col_next      = col - CW'(1);
          cur_addr_next = cur_addr - AW'(1);
          put_we        = 1'b1;
          put_addr      = cur_addr - AW'(1);
          put_data      = blank_cell;
        end
      end else begin
        put_we = 1'b1;
        if (col == LAST_COL) begin
          col_next = '0;
          if (row == LAST_ROW) begin
            go_scroll     = 1'b1;
            cur_addr_next = BOTTOM_ADDR;
          end else begin
            row_next      = row + RW'(1);
            cur_addr_next = cur_addr + AW'(1);
          end
        end else begin
          col_next      = col + CW'(1);
          cur_addr_next = cur_addr + AW'(1);
        end
      end
    end
  end

  // Write port: a pending scroll copy has priority over blanking.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = blank_cell;
    ram_raddr = read_addr;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = RESET_CELL;
      end
      ST_IDLE: begin
        ram_we    = accept && put_we;
        ram_waddr = put_addr;
        ram_wdata = put_data;
      end
      ST_SCROLL: begin
        ram_raddr = ptr + ROW_STRIDE;
        ram_we    = copy_pend;
        ram_waddr = copy_addr;
        ram_wdata = ram_rdata;
      end
      ST_BLANK: begin
        ram_we = 1'b1;
        if (copy_pend) begin
          ram_waddr = copy_addr;
          ram_wdata = ram_rdata;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (ptr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_data.command == CMD_READ) begin
            state_next = ST_READ;
          end else if (go_scroll) begin
            state_next = ST_SCROLL;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_READ:   state_next = ST_FINISH;
      ST_SCROLL: begin
        if (ptr == COPY_LAST) begin
          state_next = ST_BLANK;
        end
      end
      ST_BLANK: begin
        if (!copy_pend && ptr == LAST_ADDR) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      attr      <= RESET_ATTR;
      row       <= '0;
      col       <= '0;
      cur_addr  <= '0;
      ptr       <= '0;
      copy_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      copy_pend <= (state == ST_SCROLL);
      if (cfg_wr_en) begin
        attr <= cfg_wr_data;
      end
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          ptr <= (ptr == LAST_ADDR) ? '0 : ptr + AW'(1);
        end
        ST_IDLE: begin
          if (accept) begin
            ptr <= '0;
            if (in_data.command == CMD_PUT) begin
              row      <= row_next;
              col      <= col_next;
              cur_addr <= cur_addr_next;
            end
          end
        end
        ST_SCROLL: begin
          ptr <= ptr + AW'(1);
        end
        ST_BLANK: begin
          if (!copy_pend && ptr != LAST_ADDR) begin
            ptr <= ptr + AW'(1);
          end
        end
        default: begin
          ptr <= ptr;
        end
      endcase
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (state == ST_SCROLL) begin
      copy_addr <= ptr;
    end
    if (accept) begin
      read_ok    <= in_range;
      pend_value <= '0;
    end
    if (state == ST_READ) begin
      pend_value <= read_ok ? ram_rdata : '0;
    end
    if (state == ST_FINISH && out_free) begin
      out_data.cell_value <= pend_value;
      out_data.cursor_row <= 5'(row);
      out_data.cursor_col <= 7'(col);
    end
  end

  tcsw_cell_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* hdl/tcsw_cell_ram.sv */
// Screen cell memory: one write port and one read port, registered read data.
// Depends on tcsw_pkg for the cell type.
module tcsw_cell_ram #(
  parameter int DEPTH = tcsw_pkg::SCREEN_WIDTH_DEF * tcsw_pkg::SCREEN_HEIGHT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  tcsw_pkg::cell_t wdata,
  input  logic [AW-1:0]   raddr,
  output tcsw_pkg::cell_t rdata
);
  import tcsw_pkg::*;

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/text_console_screen_writer_unit_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for text_console_screen_writer_unit: directed and random
// puts, newlines, backspaces and reads checked against a cycle-free model of the console.
// Depends on tcsw_pkg and the RTL of the block.
module text_console_screen_writer_unit_test;
  import tcsw_pkg::*;

  localparam int ROWS = 25;
  localparam int COLS = 80;
  localparam int IDLE_LIMIT = 50000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  // Model state of the console.
  cell_t       screen [ROWS][COLS];
  int unsigned cur_row;
  int unsigned cur_col;
  logic [7:0]  text_attr;

  out_item_t   predicted_outputs [$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          stall_run = 0;
  bit          quiet = 1'b0;

  text_console_screen_writer_unit #(
    .SCREEN_WIDTH (COLS),
    .SCREEN_HEIGHT(ROWS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic void console_reset();
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLS; c++)
        screen[r][c] = RESET_CELL;
    cur_row = 0;
    cur_col = 0;
    text_attr = RESET_ATTR;
  endfunction

  function automatic void console_next_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int r = 0; r < ROWS - 1; r++)
        for (int c = 0; c < COLS; c++)
          screen[r][c] = screen[r + 1][c];
      for (int c = 0; c < COLS; c++)
        screen[ROWS - 1][c] = {text_attr, CH_SPACE};
      cur_row = ROWS - 1;
    end
  endfunction

  function automatic out_item_t console_predict(in_item_t it);
    out_item_t res;
    res = '0;
    if (it.command == CMD_READ) begin
      if (it.read_row < ROWS && it.read_col < COLS)
        res.cell_value = screen[it.read_row][it.read_col];
    end else if (it.char_code == CH_NEWLINE) begin
      console_next_line();
    end else if (it.char_code == CH_BACKSPACE) begin
      if (cur_col > 0) begin
        cur_col--;
        screen[cur_row][cur_col] = {text_attr, CH_SPACE};
      end
    end else begin
      screen[cur_row][cur_col] = {text_attr, it.char_code};
      cur_col++;
      if (cur_col >= COLS)
        console_next_line();
    end
    res.cursor_row = cur_row[4:0];
    res.cursor_col = cur_col[6:0];
    return res;
  endfunction

  function automatic int next_gap();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 60)
      return 0;
    else if (r < 92)
      return $urandom_range(3, 1);
    else
      return $urandom_range(40, 8);
  endfunction

  function automatic in_item_t put_item(logic [7:0] ch);
    in_item_t it;
    it.command = CMD_PUT;
    it.char_code = ch;
    it.read_row = 5'($urandom_range(31));
    it.read_col = 7'($urandom_range(127));
    return it;
  endfunction

  function automatic in_item_t read_item(logic [4:0] row, logic [6:0] col, logic [7:0] ch);
    in_item_t it;
    it.command = CMD_READ;
    it.char_code = ch;
    it.read_row = row;
    it.read_col = col;
    return it;
  endfunction

  function automatic in_item_t random_item();
    int kind;
    logic [4:0] row;
    kind = $urandom_range(99);
    if (kind < 45)
      return put_item(8'($urandom_range(126, 32)));
    else if (kind < 50)
      return put_item(8'($urandom_range(255)));
    else if (kind < 60)
      return put_item(CH_NEWLINE);
    else if (kind < 68)
      return put_item(CH_BACKSPACE);
    else if (kind < 90) begin
      // Half of these in-range reads look at the cursor row, where recent writes landed.
      row = $urandom_range(1) ? cur_row[4:0] : 5'($urandom_range(ROWS - 1));
      return read_item(row, 7'($urandom_range(COLS - 1)), 8'($urandom_range(255)));
    end else
      return read_item(5'($urandom_range(31)), 7'($urandom_range(127)),
                       8'($urandom_range(255)));
  endfunction

  // Sends one beat; the gap comes first so valid stays high across back-to-back beats.
  task automatic send_item(in_item_t it);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_outputs.push_back(console_predict(it));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_attribute(logic [7:0] attr);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= attr;
    @(posedge clk);
    text_attr = attr;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_reset_contents();
    send_item(read_item(5'd0, 7'd0, 8'h00));
    send_item(read_item(5'd24, 7'd79, 8'hFF));
    send_item(read_item(5'd31, 7'd127, 8'h00));
    send_item(read_item(5'd24, 7'd80, 8'h00));
    send_item(read_item(5'd25, 7'd0, 8'h00));
  endtask

  task automatic test_put_backspace();
    set_attribute(8'h00);
    send_item(put_item(8'h00));
    send_item(put_item(8'hFF));
    send_item(put_item(CH_BACKSPACE));
    send_item(read_item(5'd0, 7'd0, 8'h00));
    send_item(read_item(5'd0, 7'd1, 8'h00));
    send_item(put_item(CH_NEWLINE));
    // At column zero a backspace must leave the cursor and the cells alone.
    send_item(put_item(CH_BACKSPACE));
    send_item(read_item(5'd1, 7'd0, 8'h00));
    set_attribute(8'hFF);
    send_item(put_item("A"));
    send_item(read_item(5'd1, 7'd0, 8'h00));
  endtask

  task automatic test_read_leaves_cursor();
    send_item(read_item(5'd1, 7'd0, CH_NEWLINE));
    send_item(read_item(5'd0, 7'd0, CH_BACKSPACE));
  endtask

  task automatic test_scroll();
    set_attribute(8'h5A);
    while (cur_row < ROWS - 1) send_item(put_item(CH_NEWLINE));
    // A full bottom line wraps past the last row and scrolls.
    for (int c = 0; c < COLS; c++) send_item(put_item(8'(97 + c % 26)));
    send_item(put_item("x"));
    send_item(put_item(CH_NEWLINE));
    send_item(read_item(5'd23, 7'd0, 8'h00));
    send_item(read_item(5'd22, 7'd79, 8'h00));
    send_item(read_item(5'd24, 7'd0, 8'h00));
  endtask

  task automatic test_random_text();
    logic [7:0] attrs [4];
    attrs = '{8'h00, 8'hFF, 8'($urandom_range(255)), 8'($urandom_range(255))};
    for (int p = 0; p < 4; p++) begin
      set_attribute(attrs[p]);
      quiet = (p == 2);
      for (int i = 0; i < 200; i++) begin
        send_item(random_item());
        // Let everything come back once in the middle of a phase.
        if (i == 100 && p == 1) wait_drained();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    console_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    // The block clears the grid after reset and stalls until that is done.
    while (in_stall) @(posedge clk);
    test_reset_contents();
    test_put_backspace();
    test_read_leaves_cursor();
    test_scroll();
    test_random_text();
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("text_console_screen_writer_unit: match");
    else
      $display("text_console_screen_writer_unit: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else begin
      int r;
      r = $urandom_range(99);
      if (quiet || r < 70)
        out_stall <= 1'b0;
      else if (r < 95) begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(2);
      end else begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(39, 9);
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_outputs.size() == 0) begin
        $display("%0t: result beat expected none actual %h", $time, out_data);
        errors++;
      end else begin
        want = predicted_outputs.pop_front();
        if (out_data.cell_value !== want.cell_value) begin
          $display("%0t: cell_value expected %h actual %h",
                   $time, want.cell_value, out_data.cell_value);
          errors++;
        end
        if (out_data.cursor_row !== want.cursor_row) begin
          $display("%0t: cursor_row expected %0d actual %0d",
                   $time, want.cursor_row, out_data.cursor_row);
          errors++;
        end
        if (out_data.cursor_col !== want.cursor_col) begin
          $display("%0t: cursor_col expected %0d actual %0d",
                   $time, want.cursor_col, out_data.cursor_col);
          errors++;
        end
      end
    end
  end

  // Ends the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress, %0d results outstanding", $time, predicted_outputs.size());
      $display("text_console_screen_writer_unit: mismatch");
      $finish;
    end
  end

endmodule
